[hdl/mss_pkg.sv]
// Shared types, constants and register codes for the minmod slope stencil.
package mss_pkg;

  // Line capacity and datapath width
  localparam int MAX_WIDTH  = 1024;
  localparam int VALUE_BITS = 32;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);

  // Fixed field widths
  localparam int GW_W       = 11;
  localparam int ROW_W      = 16;
  localparam int COL_W      = 10;
  localparam int CFG_DATA_W = 16;

  localparam logic [GW_W-1:0]  GRID_WIDTH_RST  = GW_W'(1024);
  localparam logic [ROW_W-1:0] GRID_HEIGHT_RST = ROW_W'(1024);

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [ADDR_W-1:0]            addr_t;

  localparam value_t VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam value_t VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    value_t density;
    value_t velocity;
    value_t pressure;
  } in_word_t;

  typedef struct packed {
    value_t             slope_x_density;
    value_t             slope_x_velocity;
    value_t             slope_x_pressure;
    value_t             slope_y_density;
    value_t             slope_y_velocity;
    value_t             slope_y_pressure;
    logic [COL_W-1:0]   center_column;
    logic [ROW_W-1:0]   center_row;
    logic               frame_last;
  } out_word_t;

  // Per-word control decoded from the raster position
  typedef struct packed {
    addr_t              rd_mid;
    addr_t              rd_up;
    addr_t              wr;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic               emit;
    logic               last;
  } step_t;

endpackage

[hdl/mss_ctrl.sv]
// Raster position counters, grid size registers and per-word control decode.
module mss_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  mss_pkg::cfg_reg_e              cfg_idx_i,
  input  logic [mss_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           step_i,
  output mss_pkg::step_t                 step_o
);
  import mss_pkg::*;

  localparam logic [GW_W-1:0]  W_MIN = GW_W'(3);
  localparam logic [GW_W-1:0]  W_MAX = GW_W'(MAX_WIDTH);
  localparam logic [ROW_W-1:0] H_MIN = ROW_W'(3);

  logic [GW_W-1:0]   width_q;
  logic [ROW_W-1:0]  height_q;
  logic [ADDR_W-1:0] col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;

  logic [GW_W-1:0]   w_eff;
  logic [ROW_W-1:0]  h_eff;
  logic [ADDR_W-1:0] c;
  logic [ROW_W-1:0]  r;
  logic [GW_W-1:0]   c_nx;
  logic [ROW_W-1:0]  r_nx;

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= GRID_WIDTH_RST;
      height_q <= GRID_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRID_WIDTH:  width_q  <= cfg_data_i[GW_W-1:0];
        REG_GRID_HEIGHT: height_q <= cfg_data_i[ROW_W-1:0];
      endcase
    end
  end

  // Clamp grid size to the supported range
  always_comb begin
    if (width_q < W_MIN) begin
      w_eff = W_MIN;
    end else if (width_q > W_MAX) begin
      w_eff = W_MAX;
    end else begin
      w_eff = width_q;
    end
    h_eff = (height_q < H_MIN) ? H_MIN : height_q;
  end

  // Resolve the position of this word, then advance
  always_comb begin
    if (GW_W'(col_q) >= w_eff) begin
      c = '0;
      r = row_q + ROW_W'(1);
    end else begin
      c = col_q;
      r = row_q;
    end
    if (r >= h_eff) begin
      r = '0;
    end

    c_nx = GW_W'(c) + GW_W'(1);
    r_nx = r;
    if (c_nx >= w_eff) begin
      col_d = '0;
      r_nx  = r + ROW_W'(1);
      if (r_nx >= h_eff) begin
        r_nx = '0;
      end
    end else begin
      col_d = c_nx[ADDR_W-1:0];
    end
    row_d = r_nx;

    step_o.rd_mid = c;
    step_o.rd_up  = c - ADDR_W'(1);
    step_o.wr     = (c == '0) ? ADDR_W'(w_eff - GW_W'(1)) : c - ADDR_W'(1);
    step_o.col    = COL_W'(c - ADDR_W'(1));
    step_o.row    = r - ROW_W'(1);
    step_o.emit   = (c >= ADDR_W'(2)) && (r >= ROW_W'(2));
    step_o.last   = (GW_W'(c) == w_eff - GW_W'(1)) && (r == h_eff - ROW_W'(1));
  end

  // Advance the raster counters on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (step_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

[hdl/mss_lane.sv]
// One quantity's line buffers, stencil window, saturating differences and minmod.
module mss_lane (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           wr_en_i,
  input  mss_pkg::addr_t rd_mid_addr_i,
  input  mss_pkg::addr_t rd_up_addr_i,
  input  mss_pkg::addr_t wr_addr_i,
  input  mss_pkg::value_t val_i,
  output mss_pkg::value_t slope_x_o,
  output mss_pkg::value_t slope_y_o
);
  import mss_pkg::*;

  localparam int MSB = VALUE_BITS - 1;

  value_t mid_mem [MAX_WIDTH];
  value_t up_mem  [MAX_WIDTH];

  value_t right_q, up_q, cur_q;
  value_t win0_q, win1_q, prior_q;
  value_t dxa_q, dxb_q, dya_q, dyb_q;

  // a - b, clipped to the signed value range
  function automatic value_t sat_sub(value_t a, value_t b);
    logic signed [VALUE_BITS:0] d;
    d = {a[MSB], a} - {b[MSB], b};
    if (d[VALUE_BITS] != d[MSB]) begin
      return d[VALUE_BITS] ? VMIN : VMAX;
    end
    return d[MSB:0];
  endfunction

  // Zero on opposite signs, else the smaller magnitude; b wins a tie
  function automatic value_t minmod(value_t a, value_t b);
    value_t na;
    value_t nb;
    if ((a[MSB] && !b[MSB] && (b != '0)) || (!a[MSB] && (a != '0) && b[MSB])) begin
      return '0;
    end
    na = a[MSB] ? a : -a;
    nb = b[MSB] ? b : -b;
    return (na > nb) ? a : b;
  endfunction

  // Write back the column just left behind
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      up_mem[wr_addr_i]  <= win1_q;
      mid_mem[wr_addr_i] <= prior_q;
    end
  end

  // Read the line buffers for the incoming word
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      right_q <= mid_mem[rd_mid_addr_i];
      up_q    <= up_mem[rd_up_addr_i];
      cur_q   <= val_i;
    end
  end

  // Shift the center window and the previous cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win0_q  <= '0;
      win1_q  <= '0;
      prior_q <= '0;
    end else if (wr_en_i) begin
      win0_q  <= win1_q;
      win1_q  <= right_q;
      prior_q <= cur_q;
    end
  end

  // Register the one-sided differences
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dxa_q <= sat_sub(win1_q, win0_q);
      dxb_q <= sat_sub(right_q, win1_q);
      dya_q <= sat_sub(win1_q, up_q);
      dyb_q <= sat_sub(prior_q, win1_q);
    end
  end

  assign slope_x_o = minmod(dxa_q, dxb_q);
  assign slope_y_o = minmod(dya_q, dyb_q);

endmodule

[hdl/minmod_slope_stencil_2d.sv]
// Top level of the minmod slope stencil: handshake, pipeline control and lanes.
//
// Takes one grid cell per clock in raster order and returns, for each interior
// cell, minmod-limited x and y slopes of density, velocity and pressure with the
// cell's column, row and a last-of-frame flag. Throughput is one word per cycle
// with no stall of its own; once the word completing its stencil is accepted, the
// result passes the line-buffer read register, the difference register, then the
// limiter feeding the output register, and is presented. Boundary cells produce
// no word. Two block RAMs per quantity hold the previous rows; their contents
// need no clearing after reset, so the block takes words right away. The whole
// pipeline holds while a finished word waits on out_stall_i. Write grid_width
// and grid_height only while the block is empty.
module minmod_slope_stencil_2d (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  mss_pkg::cfg_reg_e              cfg_idx_i,
  input  logic [mss_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  mss_pkg::in_word_t              in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output mss_pkg::out_word_t             out_word_o
);
  import mss_pkg::*;

  logic      en;
  logic      a_fire;
  logic      b_fire;
  step_t     step_a;
  step_t     meta_b_q, meta_c_q;
  logic      vb_q, vc_q, vo_q;
  out_word_t out_q;
  value_t    sx_d, sx_v, sx_p, sy_d, sy_v, sy_p;

  // Advance everything unless a finished word is held
  assign en         = !vo_q || !out_stall_i;
  assign in_stall_o = !en;
  assign a_fire     = in_valid_i && en;
  assign b_fire     = vb_q && en;

  mss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (a_fire),
    .step_o     (step_a)
  );

  mss_lane u_lane_density (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .wr_en_i       (b_fire),
    .rd_mid_addr_i (step_a.rd_mid),
    .rd_up_addr_i  (step_a.rd_up),
    .wr_addr_i     (meta_b_q.wr),
    .val_i         (in_word_i.density),
    .slope_x_o     (sx_d),
    .slope_y_o     (sy_d)
  );

  mss_lane u_lane_velocity (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .wr_en_i       (b_fire),
    .rd_mid_addr_i (step_a.rd_mid),
    .rd_up_addr_i  (step_a.rd_up),
    .wr_addr_i     (meta_b_q.wr),
    .val_i         (in_word_i.velocity),
    .slope_x_o     (sx_v),
    .slope_y_o     (sy_v)
  );

  mss_lane u_lane_pressure (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .wr_en_i       (b_fire),
    .rd_mid_addr_i (step_a.rd_mid),
    .rd_up_addr_i  (step_a.rd_up),
    .wr_addr_i     (meta_b_q.wr),
    .val_i         (in_word_i.pressure),
    .slope_x_o     (sx_p),
    .slope_y_o     (sy_p)
  );

  // Track valid words through the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      vb_q <= in_valid_i;
      vc_q <= vb_q && meta_b_q.emit;
      vo_q <= vc_q;
    end
  end

  // Carry position data alongside and load the output word
  always_ff @(posedge clk_i) begin
    if (en) begin
      meta_b_q <= step_a;
      meta_c_q <= meta_b_q;
      out_q.slope_x_density  <= sx_d;
      out_q.slope_x_velocity <= sx_v;
      out_q.slope_x_pressure <= sx_p;
      out_q.slope_y_density  <= sy_d;
      out_q.slope_y_velocity <= sy_v;
      out_q.slope_y_pressure <= sy_p;
      out_q.center_column    <= meta_c_q.col;
      out_q.center_row       <= meta_c_q.row;
      out_q.frame_last       <= meta_c_q.last;
    end
  end

  assign out_valid_o = vo_q;
  assign out_word_o  = out_q;

endmodule

[test/tb_minmod_slope_stencil_2d.sv]
// Self-checking testbench for the 2D minmod slope stencil: raster frames in, limited slopes out.
`timescale 1ns / 1ps

module tb_minmod_slope_stencil_2d;
  import mss_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned STUCK_LIMIT   = 4000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned RANDOM_CELLS  = 700;
  localparam int unsigned RANDOM_SLACK  = 60;
  localparam int unsigned QUIET_FROM    = 800;
  localparam int unsigned QUIET_TO      = 1600;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  cfg_reg_e              cfg_idx_i   = REG_GRID_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_word_t              in_word_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_word_t             out_word_o;

  minmod_slope_stencil_2d dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Bookkeeping shared by driver, monitor and sequencer
  in_word_t    cell_q [$];
  out_word_t   slopes_q [$];
  int unsigned cells_pushed = 0;
  int unsigned cells_taken  = 0;
  int unsigned errors       = 0;
  int unsigned stuck_cycles = 0;
  int unsigned cyc          = 0;
  logic        cell_took    = 1'b0;
  logic        hold_req     = 1'b0;
  logic        hold_used    = 1'b0;
  int unsigned hold_left    = 0;
  wire         quiet        = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

  // Shadow of the block: registers, line buffers, window and raster position
  logic [GW_W-1:0]  grid_w_reg = GRID_WIDTH_RST;
  logic [ROW_W-1:0] grid_h_reg = GRID_HEIGHT_RST;
  in_word_t         up_line  [MAX_WIDTH];
  in_word_t         mid_line [MAX_WIDTH];
  in_word_t         win_left   = '0;
  in_word_t         win_centre = '0;
  in_word_t         last_cell  = '0;
  int unsigned      col_pos    = 0;
  int unsigned      row_pos    = 0;

  function automatic int unsigned eff_width(logic [GW_W-1:0] raw);
    if (raw < 3) return 3;
    if (raw > MAX_WIDTH) return MAX_WIDTH;
    return 32'(raw);
  endfunction

  function automatic int unsigned eff_height(logic [ROW_W-1:0] raw);
    return (raw < 3) ? 3 : 32'(raw);
  endfunction

  // Difference a - b, saturated to the value range
  function automatic value_t clamp_sub(value_t a, value_t b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d > longint'(VMAX)) d = longint'(VMAX);
    if (d < longint'(VMIN)) d = longint'(VMIN);
    return value_t'(d);
  endfunction

  // Zero on opposite signs, else the smaller magnitude; forward wins a tie
  function automatic value_t minmod(value_t back, value_t fwd);
    longint nb, nf;
    if ((back < 0 && fwd > 0) || (back > 0 && fwd < 0)) return '0;
    nb = (back < 0) ? longint'(back) : -longint'(back);
    nf = (fwd < 0) ? longint'(fwd) : -longint'(fwd);
    return (nb > nf) ? back : fwd;
  endfunction

  function automatic value_t limited_slope(value_t lo, value_t mid, value_t hi);
    return minmod(clamp_sub(mid, lo), clamp_sub(hi, mid));
  endfunction

  // Advance the stencil by one cell and queue the slopes it completes
  function automatic void advance_stencil(in_word_t cur);
    int unsigned w, h, c, r, pc;
    in_word_t    right, up;
    out_word_t   res;
    w = eff_width(grid_w_reg);
    h = eff_height(grid_h_reg);
    c = col_pos;
    r = row_pos;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r >= h) r = 0;
    right = mid_line[c];
    if (c >= 2 && r >= 2) begin
      up = up_line[c-1];
      res.slope_x_density  = limited_slope(win_left.density, win_centre.density, right.density);
      res.slope_x_velocity = limited_slope(win_left.velocity, win_centre.velocity,
                                           right.velocity);
      res.slope_x_pressure = limited_slope(win_left.pressure, win_centre.pressure,
                                           right.pressure);
      res.slope_y_density  = limited_slope(up.density, win_centre.density, last_cell.density);
      res.slope_y_velocity = limited_slope(up.velocity, win_centre.velocity,
                                           last_cell.velocity);
      res.slope_y_pressure = limited_slope(up.pressure, win_centre.pressure,
                                           last_cell.pressure);
      res.center_column    = COL_W'(c - 1);
      res.center_row       = ROW_W'(r - 1);
      res.frame_last       = (c == w - 1) && (r == h - 1);
      slopes_q.push_back(res);
    end
    // write back the column just left behind, then shift the window
    pc = (c == 0) ? w - 1 : c - 1;
    up_line[pc]  = win_centre;
    mid_line[pc] = last_cell;
    win_left     = win_centre;
    win_centre   = right;
    last_cell    = cur;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  function automatic void check_field(string name, logic [VALUE_BITS-1:0] want,
                                      logic [VALUE_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t mismatch %s: expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Sample both channels and the config port at the rising edge
  always @(posedge clk_i) begin
    out_word_t want;
    logic      in_hit, out_hit;
    in_hit  = rst_ni && in_valid_i && !in_stall_o;
    out_hit = rst_ni && out_valid_o && !out_stall_i;
    cell_took <= in_hit;
    if (rst_ni) begin
      cyc <= cyc + 1;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GRID_WIDTH:  grid_w_reg = cfg_data_i[GW_W-1:0];
          REG_GRID_HEIGHT: grid_h_reg = cfg_data_i[ROW_W-1:0];
          default: ;
        endcase
      end
      if (in_hit) begin
        advance_stencil(in_word_i);
        cells_taken++;
      end
      if (out_hit) begin
        if (slopes_q.size() == 0) begin
          $display("%0t mismatch unexpected word: expected none, got %h", $time, out_word_o);
          errors++;
        end else begin
          want = slopes_q.pop_front();
          check_field("slope_x_density", want.slope_x_density, out_word_o.slope_x_density);
          check_field("slope_x_velocity", want.slope_x_velocity, out_word_o.slope_x_velocity);
          check_field("slope_x_pressure", want.slope_x_pressure, out_word_o.slope_x_pressure);
          check_field("slope_y_density", want.slope_y_density, out_word_o.slope_y_density);
          check_field("slope_y_velocity", want.slope_y_velocity, out_word_o.slope_y_velocity);
          check_field("slope_y_pressure", want.slope_y_pressure, out_word_o.slope_y_pressure);
          check_field("center_column", VALUE_BITS'(want.center_column),
                      VALUE_BITS'(out_word_o.center_column));
          check_field("center_row", VALUE_BITS'(want.center_row),
                      VALUE_BITS'(out_word_o.center_row));
          check_field("frame_last", VALUE_BITS'(want.frame_last),
                      VALUE_BITS'(out_word_o.frame_last));
        end
      end
      stuck_cycles <= (in_hit || out_hit || cfg_we_i) ? 0 : stuck_cycles + 1;
    end
  end

  // Offer the next word once the current one is taken; hold it while stalled
  always @(negedge clk_i) begin
    if (!in_valid_i || cell_took) begin
      if (cell_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 24)) begin
        in_word_i  <= cell_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Drive receiver back-pressure: random stalls plus one long hold-off
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_req && !hold_used && out_valid_o) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_used   <= 1'b1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(0, 99) < 24);
    end
  end

  // Abort when nothing moves for too long
  initial begin : watchdog
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic value_t pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return value_t'($urandom);
      3, 4:    return value_t'(int'($urandom_range(0, 8)) - 4);
      5:       return VMAX;
      6:       return VMIN;
      7:       return VMAX - value_t'($urandom_range(0, 3));
      8:       return VMIN + value_t'($urandom_range(0, 3));
      default: return '0;
    endcase
  endfunction

  task automatic queue_cell(in_word_t pt);
    cell_q.push_back(pt);
    cells_pushed++;
  endtask

  task automatic queue_frames(int unsigned w, int unsigned h, int unsigned frames);
    in_word_t pt;
    for (int unsigned n = 0; n < frames * w * h; n++) begin
      pt.density  = pick_value();
      pt.velocity = pick_value();
      pt.pressure = pick_value();
      queue_cell(pt);
    end
  endtask

  // Wait until every word is in and every slope is out, then let the pipe empty
  task automatic wait_idle();
    while (cells_taken != cells_pushed || slopes_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_grid(input logic [CFG_DATA_W-1:0] w_data, input logic [CFG_DATA_W-1:0] h_data,
                          output int unsigned w_eff, output int unsigned h_eff);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_GRID_WIDTH;
    cfg_data_i <= w_data;
    @(negedge clk_i);
    cfg_idx_i  <= REG_GRID_HEIGHT;
    cfg_data_i <= h_data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    w_eff = eff_width(w_data[GW_W-1:0]);
    h_eff = eff_height(h_data[ROW_W-1:0]);
  endtask

  // Sequence: reset, directed frame, random small frames, one wide frame
  initial begin
    int unsigned      w, h, frames, random_cells;
    logic [GW_W-1:0]  wraw;
    logic [ROW_W-1:0] hraw;
    in_word_t         pt;
    random_cells = 0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      up_line[i]  = '0;
      mid_line[i] = '0;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // equal steps give magnitude ties, alternating extremes saturate with
    // opposite signs, and the pressure lane mixes the corner values
    set_grid(16'd5, 16'd5, w, h);
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 5; c++) begin
        pt.density  = value_t'(c * 65536 + r * 3);
        pt.velocity = ((c + r) % 2 == 1) ? VMAX : VMIN;
        case ((c * 3 + r) % 5)
          0:       pt.pressure = VMIN;
          1:       pt.pressure = VMAX;
          2:       pt.pressure = '0;
          3:       pt.pressure = -1;
          default: pt.pressure = 1;
        endcase
        queue_cell(pt);
      end
    end

    // mostly small grids, some below the minimum size, junk in unused bits
    while (random_cells < RANDOM_CELLS) begin
      case ($urandom_range(0, 9))
        0:       wraw = GW_W'($urandom_range(0, 2));
        1:       wraw = GW_W'($urandom_range(13, 40));
        default: wraw = GW_W'($urandom_range(3, 12));
      endcase
      case ($urandom_range(0, 9))
        0:       hraw = ROW_W'($urandom_range(0, 2));
        1:       hraw = ROW_W'($urandom_range(9, 20));
        default: hraw = ROW_W'($urandom_range(3, 8));
      endcase
      // skip a size that would run far past the word budget
      if (random_cells + eff_width(wraw) * eff_height(hraw) > RANDOM_CELLS + RANDOM_SLACK)
        continue;
      set_grid({5'($urandom), wraw}, hraw, w, h);
      frames = $urandom_range(1, 3);
      while (frames > 1 && random_cells + frames * w * h > RANDOM_CELLS + RANDOM_SLACK)
        frames--;
      queue_frames(w, h, frames);
      random_cells += frames * w * h;
    end

    // wide rows, with the long output hold-off once slopes start flowing
    set_grid(16'd200, 16'd3, w, h);
    queue_frames(w, h, 1);
    hold_req = 1'b1;

    wait_idle();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
